// ===== sv/assert_macros.svh =====
// Assertion macros for the stroke-to-quad RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASRT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASRT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASRT_IMPL(lbl, ante, cons, msg)
`define ASRT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/pstq_pkg.sv =====
// Shared types and constants for the polyline stroke-to-quad block.
package pstq_pkg;

  localparam int CW = 32;   // coordinate width, signed
  localparam int WW = 31;   // stroke width field, unsigned

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_LOAD, ST_NORM, ST_MUL, ST_SQI, ST_SQRT,
    ST_DVI, ST_DIV, ST_LDV, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MUL_SQA, MUL_SUM, MUL_NUMX, MUL_NUMY
  } mul_op_t;

  typedef struct packed {
    logic    accept;
    logic    load_seg;
    logic    seg_sel;     // 0: previous to current, 1: current to start
    logic    norm_step;
    logic    mul;
    mul_op_t mul_op;
    logic    sqrt_init;
    logic    sqrt_step;
    logic    div_init;
    logic    div_step;
    logic    load_out;
    logic [1:0] corner;
    logic    last;
    logic    out_take;
  } cmd_t;

  typedef struct packed {
    logic do1;
    logic do2;
    logic norm_ok;
  } status_t;

endpackage

// ===== sv/pstq_ctrl.sv =====
// Sequencer for the per-segment normal computation and corner output.
module pstq_ctrl
  import pstq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t st,
  output cmd_t    cmd
);

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       seg_r, seg_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    seg_nxt   = seg_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_PREP;
      ST_PREP: begin
        if (st.do1) begin
          seg_nxt = 1'b0; state_nxt = ST_LOAD;
        end else if (st.do2) begin
          seg_nxt = 1'b1; state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LOAD: state_nxt = ST_NORM;
      ST_NORM: if (st.norm_ok) begin
        state_nxt = ST_MUL; cnt_nxt = 6'd0;
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd3) state_nxt = ST_SQI;
      end
      ST_SQI: begin
        state_nxt = ST_SQRT; cnt_nxt = 6'd0;
      end
      ST_SQRT: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd30) state_nxt = ST_DVI;
      end
      ST_DVI: begin
        state_nxt = ST_DIV; cnt_nxt = 6'd0;
      end
      ST_DIV: begin
        if (cnt_r == 6'd31) begin
          state_nxt = ST_LDV; cnt_nxt = 6'd0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_LDV: state_nxt = ST_EMIT;
      ST_EMIT: if (!out_stall) begin
        if (cnt_r == 6'd3) begin
          if (!seg_r && st.do2) begin
            seg_nxt = 1'b1; state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r + 6'd1; state_nxt = ST_LDV;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    cmd.seg_sel   = seg_r;
    cmd.mul_op    = mul_op_t'(cnt_r[1:0]);
    cmd.corner    = cnt_r[1:0];
    cmd.last      = (cnt_r == 6'd3) && (seg_r || !st.do2);
    in_stall      = (state_r != ST_IDLE);
    out_valid     = (state_r == ST_EMIT);
    unique case (state_r)
      ST_IDLE:  cmd.accept    = in_valid;
      ST_LOAD:  cmd.load_seg  = 1'b1;
      ST_NORM:  cmd.norm_step = !st.norm_ok;
      ST_MUL:   cmd.mul       = 1'b1;
      ST_SQI:   cmd.sqrt_init = 1'b1;
      ST_SQRT:  cmd.sqrt_step = 1'b1;
      ST_DVI:   cmd.div_init  = 1'b1;
      ST_DIV:   cmd.div_step  = 1'b1;
      ST_LDV:   cmd.load_out  = 1'b1;
      ST_EMIT:  cmd.out_take  = !out_stall;
      default:  cmd.accept    = 1'b0;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 6'd0;
      seg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      seg_r   <= seg_nxt;
    end
  end

endmodule

// ===== sv/pstq_dp.sv =====
// Datapath: point state, normalize, square root, divide and corner sums.
`include "assert_macros.svh"
module pstq_dp
  import pstq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output status_t              st,
  input  logic signed [CW-1:0] in_point_x,
  input  logic signed [CW-1:0] in_point_y,
  input  logic [WW-1:0]        in_stroke_width,
  input  logic [31:0]          in_color_rgba,
  input  logic                 in_first_point,
  input  logic                 in_last_point,
  input  logic                 in_closed_path,
  input  logic                 in_restart_count,
  output logic signed [CW-1:0] out_vertex_x,
  output logic signed [CW-1:0] out_vertex_y,
  output logic [31:0]          out_vertex_color,
  output logic [31:0]          out_vertex_index,
  output logic [1:0]           out_corner,
  output logic                 out_run_last
);

  // point state
  logic signed [CW-1:0] prev_x_r, prev_y_r, start_x_r, start_y_r;
  logic signed [CW-1:0] old_x_r, old_y_r, cur_x_r, cur_y_r;
  logic                 have_prev_r;
  logic [31:0]          vcount_r;
  logic [WW-1:0]        w_r;
  logic [31:0]          color_r;
  logic                 do1_r, do2_r;

  // segment
  logic signed [CW-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [CW:0]          ax_r, ay_r;
  logic                 dx_neg_r, dy_pos_r;

  // arithmetic
  logic [59:0] sqa_r;
  logic [61:0] sum_r, rem_r, root_r, bit_r;
  logic [60:0] numx_r, numy_r;
  logic [31:0] rx_r, ry_r, qx_r, qy_r;
  logic [31:0] dvs_r;

  logic                 new_start;
  logic signed [CW-1:0] nsx, nsy;
  logic signed [CW:0]   dx, dy;
  logic signed [CW-1:0] seg_sx, seg_sy, seg_ex, seg_ey;
  logic [CW:0]          m;
  logic [59:0]          sqb;
  logic [61:0]          sq_t;
  logic [63:0]          dvx, dvy;
  logic [32:0]          tx, ty;
  logic                 gex, gey;
  logic signed [CW:0]   nx, ny;
  logic signed [CW+1:0] vx, vy;
  logic                 base_s, add_n;

  assign new_start = in_first_point || !have_prev_r;
  assign nsx = new_start ? in_point_x : start_x_r;
  assign nsy = new_start ? in_point_y : start_y_r;

  assign seg_sx = cmd.seg_sel ? cur_x_r   : old_x_r;
  assign seg_sy = cmd.seg_sel ? cur_y_r   : old_y_r;
  assign seg_ex = cmd.seg_sel ? start_x_r : cur_x_r;
  assign seg_ey = cmd.seg_sel ? start_y_r : cur_y_r;
  assign dx = {seg_ex[CW-1], seg_ex} - {seg_sx[CW-1], seg_sx};
  assign dy = {seg_ey[CW-1], seg_ey} - {seg_sy[CW-1], seg_sy};

  assign m = (ax_r > ay_r) ? ax_r : ay_r;
  assign st.norm_ok = (m[CW:30] == '0) && m[29];
  assign st.do1 = do1_r;
  assign st.do2 = do2_r;

  assign sqb  = ay_r[29:0] * ay_r[29:0];
  assign sq_t = root_r + bit_r;
  assign dvx  = {3'b000, numx_r} + {32'd0, root_r[31:0]};
  assign dvy  = {3'b000, numy_r} + {32'd0, root_r[31:0]};
  assign tx   = {rx_r, qx_r[31]};
  assign ty   = {ry_r, qy_r[31]};
  assign gex  = tx >= {1'b0, dvs_r};
  assign gey  = ty >= {1'b0, dvs_r};

  // normal with sign, corner sums
  assign nx = dy_pos_r ? -$signed({1'b0, qx_r}) : $signed({1'b0, qx_r});
  assign ny = dx_neg_r ? -$signed({1'b0, qy_r}) : $signed({1'b0, qy_r});
  assign base_s = (cmd.corner == 2'd0) || (cmd.corner == 2'd3);
  assign add_n  = !cmd.corner[1];
  assign vx = add_n ? ({{2{(base_s ? sx_r[CW-1] : ex_r[CW-1])}}, (base_s ? sx_r : ex_r)} +
                       {nx[CW], nx})
                    : ({{2{(base_s ? sx_r[CW-1] : ex_r[CW-1])}}, (base_s ? sx_r : ex_r)} -
                       {nx[CW], nx});
  assign vy = add_n ? ({{2{(base_s ? sy_r[CW-1] : ey_r[CW-1])}}, (base_s ? sy_r : ey_r)} +
                       {ny[CW], ny})
                    : ({{2{(base_s ? sy_r[CW-1] : ey_r[CW-1])}}, (base_s ? sy_r : ey_r)} -
                       {ny[CW], ny});

  function automatic logic signed [CW-1:0] sat(input logic signed [CW+1:0] v);
    logic signed [CW-1:0] r;
    if (v[CW+1:CW-1] == 3'b000 || v[CW+1:CW-1] == 3'b111) r = v[CW-1:0];
    else if (v[CW+1]) r = {1'b1, {(CW-1){1'b0}}};
    else r = {1'b0, {(CW-1){1'b1}}};
    return r;
  endfunction

  // control state: point history and vertex counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0; prev_y_r <= '0; start_x_r <= '0; start_y_r <= '0;
      have_prev_r <= 1'b0;
      vcount_r <= '0;
      do1_r <= 1'b0; do2_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        prev_x_r <= in_point_x; prev_y_r <= in_point_y;
        start_x_r <= nsx; start_y_r <= nsy;
        have_prev_r <= !in_last_point;
        do1_r <= !new_start && !(prev_x_r == in_point_x && prev_y_r == in_point_y);
        do2_r <= in_last_point && in_closed_path &&
                 !(nsx == in_point_x && nsy == in_point_y);
        if (in_restart_count) vcount_r <= '0;
      end else if (cmd.out_take) begin
        vcount_r <= vcount_r + 32'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      old_x_r <= prev_x_r; old_y_r <= prev_y_r;
      cur_x_r <= in_point_x; cur_y_r <= in_point_y;
      w_r <= in_stroke_width; color_r <= in_color_rgba;
    end
    // latch segment, take magnitudes
    if (cmd.load_seg) begin
      sx_r <= seg_sx; sy_r <= seg_sy; ex_r <= seg_ex; ey_r <= seg_ey;
      ax_r <= dx[CW] ? -dx : dx;
      ay_r <= dy[CW] ? -dy : dy;
      dx_neg_r <= dx[CW];
      dy_pos_r <= !dy[CW] && (dy != '0);
    end
    // normalize one bit per cycle
    if (cmd.norm_step) begin
      if (m[CW:30] != '0) begin
        ax_r <= ax_r >> 1; ay_r <= ay_r >> 1;
      end else begin
        ax_r <= ax_r << 1; ay_r <= ay_r << 1;
      end
    end
    if (cmd.mul) begin
      unique case (cmd.mul_op)
        MUL_SQA:  sqa_r  <= ax_r[29:0] * ax_r[29:0];
        MUL_SUM:  sum_r  <= {2'b00, sqa_r} + {2'b00, sqb};
        MUL_NUMX: numx_r <= ay_r[29:0] * w_r;
        MUL_NUMY: numy_r <= ax_r[29:0] * w_r;
        default:  sqa_r  <= sqa_r;
      endcase
    end
    // square root, two bits per step
    if (cmd.sqrt_init) begin
      rem_r <= sum_r; root_r <= '0; bit_r <= 62'd1 << 60;
    end else if (cmd.sqrt_step) begin
      if (rem_r >= sq_t) begin
        rem_r <= rem_r - sq_t; root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    // restoring divide, one quotient bit per step
    if (cmd.div_init) begin
      dvs_r <= {root_r[30:0], 1'b0};
      rx_r <= dvx[63:32]; qx_r <= dvx[31:0];
      ry_r <= dvy[63:32]; qy_r <= dvy[31:0];
    end else if (cmd.div_step) begin
      rx_r <= gex ? 32'(tx - {1'b0, dvs_r}) : tx[31:0];
      ry_r <= gey ? 32'(ty - {1'b0, dvs_r}) : ty[31:0];
      qx_r <= {qx_r[30:0], gex};
      qy_r <= {qy_r[30:0], gey};
    end
    // result register
    if (cmd.load_out) begin
      out_vertex_x     <= sat(vx);
      out_vertex_y     <= sat(vy);
      out_vertex_color <= color_r;
      out_corner       <= cmd.corner;
      out_run_last     <= cmd.last;
    end
  end

  assign out_vertex_index = vcount_r;

  `ASRT_IMPL(a_mul_norm, cmd.mul, ax_r[CW:30] == '0 && ay_r[CW:30] == '0, "unnormalized operand")
  `ASRT_IMPL(a_seg_do, cmd.load_seg, cmd.seg_sel ? do2_r : do1_r, "segment without work")
  `ASRT_NEXT(a_take_cnt, cmd.out_take, vcount_r == $past(vcount_r) + 32'd1, "index not advanced")

endmodule

// ===== sv/polyline_stroke_to_quads.sv =====
// Top level: polyline points in, thick-line quad corners out.
// Each segment runs a normalize loop, a multiply sequence, a 31-step square root
// and a 32-step divide before its first corner; corners wait on any output stall.
// An item with no segment emits nothing, others emit one quad or two;
// one item at a time, with in_stall high while busy.
// Reset (rst_n low, synchronous) clears point history, vertex index and control.
module polyline_stroke_to_quads
  import pstq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] in_point_x,
  input  logic signed [CW-1:0] in_point_y,
  input  logic [WW-1:0]        in_stroke_width,
  input  logic [31:0]          in_color_rgba,
  input  logic                 in_first_point,
  input  logic                 in_last_point,
  input  logic                 in_closed_path,
  input  logic                 in_restart_count,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [CW-1:0] out_vertex_x,
  output logic signed [CW-1:0] out_vertex_y,
  output logic [31:0]          out_vertex_color,
  output logic [31:0]          out_vertex_index,
  output logic [1:0]           out_corner,
  output logic                 out_run_last
);

  cmd_t    cmd;
  status_t st;

  pstq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .st, .cmd
  );

  pstq_dp u_dp (
    .clk, .rst_n, .cmd, .st,
    .in_point_x, .in_point_y, .in_stroke_width, .in_color_rgba,
    .in_first_point, .in_last_point, .in_closed_path, .in_restart_count,
    .out_vertex_x, .out_vertex_y, .out_vertex_color, .out_vertex_index,
    .out_corner, .out_run_last
  );

endmodule

// ===== verif/polyline_stroke_to_quads_test.sv =====
// Self-checking test of the polyline stroke-to-quad block against a built-in predictor.
`timescale 1ns / 100ps

module polyline_stroke_to_quads_test
  import pstq_pkg::*;
();

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [WW-1:0]        w;
    logic [31:0]          color;
    bit first, last, closed, restart;
  } point_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          color;
    logic [31:0]          index;
    logic [1:0]           corner;
    logic                 run_last;
  } vertex_t;

  // Predicts quad corners and checks the vertices that come out
  class quad_scoreboard;
    longint prev_x, prev_y, start_x, start_y;
    bit open_line;
    bit [31:0] count;
    vertex_t pending[$];
    int errors;

    function void clear();
      prev_x = 0; prev_y = 0; start_x = 0; start_y = 0;
      open_line = 0; count = 0; pending.delete(); errors = 0;
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void extrude(longint sx, longint sy, longint ex, longint ey,
                          longint unsigned w, logic [31:0] color);
      longint dx, dy, nx, ny, bx, by, vx, vy;
      longint unsigned ax, ay, m, len, mx, my;
      int bl;
      vertex_t v;
      dx = ex - sx; dy = ey - sy;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (ax == 0 && ay == 0) return;
      m = ax > ay ? ax : ay;
      bl = 0;
      while (bl < 63 && (m >> bl) != 0) bl++;
      if (bl > 30) begin
        ax >>= (bl - 30); ay >>= (bl - 30);
      end else begin
        ax <<= (30 - bl); ay <<= (30 - bl);
      end
      len = root(ax * ax + ay * ay);
      mx = (ay * w + len) / (2 * len);
      my = (ax * w + len) / (2 * len);
      nx = dy > 0 ? -longint'(mx) : longint'(mx);
      ny = dx < 0 ? -longint'(my) : longint'(my);
      for (int c = 0; c < 4; c++) begin
        bx = (c == 0 || c == 3) ? sx : ex;
        by = (c == 0 || c == 3) ? sy : ey;
        vx = c < 2 ? bx + nx : bx - nx;
        vy = c < 2 ? by + ny : by - ny;
        v.x = CW'(clamp(vx)); v.y = CW'(clamp(vy)); v.color = color;
        v.index = count; v.corner = 2'(c); v.run_last = 0;
        pending = {pending, v};
        count++;
      end
    endfunction

    function void note_point(point_t p);
      int before_n;
      before_n = pending.size();
      if (p.restart) count = 0;
      if (p.first || !open_line) begin
        start_x = p.x; start_y = p.y;
      end else begin
        extrude(prev_x, prev_y, p.x, p.y, p.w, p.color);
      end
      if (p.last && p.closed) extrude(p.x, p.y, start_x, start_y, p.w, p.color);
      prev_x = p.x; prev_y = p.y;
      open_line = !p.last;
      if (pending.size() > before_n) pending[pending.size() - 1].run_last = 1;
    endfunction

    function void check_vertex(vertex_t a);
      vertex_t e;
      if (pending.size() == 0) begin
        $error("vertex index %0d arrived with nothing expected", a.index);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.x !== e.x) begin
        $error("vertex_x expected %0d got %0d", e.x, a.x); errors++;
      end
      if (a.y !== e.y) begin
        $error("vertex_y expected %0d got %0d", e.y, a.y); errors++;
      end
      if (a.color !== e.color) begin
        $error("vertex_color expected %h got %h", e.color, a.color); errors++;
      end
      if (a.index !== e.index) begin
        $error("vertex_index expected %0d got %0d", e.index, a.index); errors++;
      end
      if (a.corner !== e.corner) begin
        $error("corner expected %0d got %0d", e.corner, a.corner); errors++;
      end
      if (a.run_last !== e.run_last) begin
        $error("run_last expected %0d got %0d", e.run_last, a.run_last); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [CW-1:0] in_point_x, in_point_y, out_vertex_x, out_vertex_y;
  logic [WW-1:0] in_stroke_width;
  logic [31:0] in_color_rgba, out_vertex_color, out_vertex_index;
  logic in_first_point, in_last_point, in_closed_path, in_restart_count;
  logic [1:0] out_corner;
  logic out_run_last;

  quad_scoreboard board;
  bit calm;          // no idling in the closing stretch
  longint cycles = 0;

  polyline_stroke_to_quads u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Run limit for 400+ items: report a failure if the cycle counter overruns
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Check vertices at the rising edge
  always @(posedge clk) begin
    vertex_t v;
    if (rst_n && out_valid && !out_stall) begin
      v.x = out_vertex_x; v.y = out_vertex_y; v.color = out_vertex_color;
      v.index = out_vertex_index; v.corner = out_corner; v.run_last = out_run_last;
      board.check_vertex(v);
    end
  end

  // Stall the result side in random bursts
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 13);
        out_stall = 1;
        repeat (n) @(negedge clk);
        out_stall = 0;
      end
    end
  end

  task automatic send_point(point_t p);
    if (!calm && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 13)) @(negedge clk);
    in_valid = 1;
    in_point_x = p.x; in_point_y = p.y; in_stroke_width = p.w;
    in_color_rgba = p.color; in_first_point = p.first; in_last_point = p.last;
    in_closed_path = p.closed; in_restart_count = p.restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_point(p);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic wait_drained();
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  function automatic point_t make_point(longint x, longint y, longint unsigned w,
                                        bit first, bit last, bit closed, bit restart);
    point_t p;
    p.x = CW'(x); p.y = CW'(y); p.w = WW'(w); p.color = $urandom;
    p.first = first; p.last = last; p.closed = closed; p.restart = restart;
    return p;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $urandom_range(0, 1) ? 32'sh7fff_fff0 + $urandom_range(0, 15)
                                     : 32'sh8000_0000 + $urandom_range(0, 15);
      default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic logic [WW-1:0] rand_width();
    case ($urandom_range(0, 3))
      0: return WW'($urandom);
      1: return WW'($urandom_range(0, 32'h0010_0000));
      2: return $urandom_range(0, 1) ? '1 : '0;
      default: return WW'($urandom_range(0, 32'h7fff_ffff));
    endcase
  endfunction

  task automatic send_line(ref int sent);
    int len;
    bit closed;
    point_t p;
    len = $urandom_range(1, 6);
    closed = $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      p.x = rand_coord(); p.y = rand_coord(); p.w = rand_width(); p.color = $urandom;
      p.first = (i == 0); p.last = (i == len - 1); p.closed = closed;
      p.restart = ($urandom_range(0, 19) == 0);
      if ($urandom_range(0, 15) == 0 && i > 0) begin
        p.x = CW'(board.prev_x); p.y = CW'(board.prev_y);   // zero-length segment
      end
      send_point(p);
      sent++;
    end
  endtask

  initial begin
    point_t p;
    int sent;
    board = new();
    board.clear();
    calm = 0;
    in_valid = 0; in_point_x = 0; in_point_y = 0; in_stroke_width = 0;
    in_color_rgba = 0; in_first_point = 0; in_last_point = 0;
    in_closed_path = 0; in_restart_count = 0;
    rst_n = 0;
    repeat (7) @(negedge clk);
    rst_n = 1;

    // Directed: extremes, orphan point, zero length, first+last, closing segment
    send_point(make_point(10, 20, 100, 0, 0, 0, 0));          // no predecessor
    send_point(make_point(10, 20, 100, 0, 0, 0, 0));          // zero length
    send_point(make_point(32'sh7fffffff, 32'sh7fffffff, '1, 0, 0, 0, 0));
    send_point(make_point(-64'sd2147483648, -64'sd2147483648, '1, 0, 0, 0, 0));
    send_point(make_point(-64'sd2147483648, 32'sh7fffffff, 0, 0, 0, 0, 0));
    send_point(make_point(0, 0, 32'h0001_0000, 0, 1, 1, 0));  // closes back
    send_point(make_point(5, 5, 777, 1, 1, 1, 0));            // first and last
    send_point(make_point(0, 0, 32'h0002_0000, 1, 0, 0, 1));
    send_point(make_point(32'h0010_0000, 0, 32'h0002_0000, 0, 0, 0, 0));
    send_point(make_point(32'h0010_0000, 32'h0010_0000, 32'h0002_0000, 0, 0, 0, 1));
    send_point(make_point(-3, 7, 32'h0004_0000, 0, 1, 1, 0));
    send_point(make_point(1, 1, 3, 0, 1, 0, 0));              // orphan last, open
    send_point(make_point(-1, -1, 5, 1, 0, 0, 0));
    send_point(make_point(1, -1, 5, 0, 1, 1, 1));
    // Hold off until every corner has drained
    wait_drained();

    // Random polylines with some loose points mixed in
    sent = 0;
    while (sent < 400) begin
      if (sent > 340) calm = 1;
      if ($urandom_range(0, 9) == 0) begin
        p.x = rand_coord(); p.y = rand_coord(); p.w = rand_width(); p.color = $urandom;
        p.first = $urandom_range(0, 1); p.last = $urandom_range(0, 1);
        p.closed = $urandom_range(0, 1); p.restart = $urandom_range(0, 1);
        send_point(p);
        sent++;
      end else begin
        send_line(sent);
      end
    end

    wait_drained();
    repeat (300) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
